>>> src/tspd_pkg.sv
// Shared types and constants for the transport stream packet demultiplexer.
`timescale 1ns / 1ps
`default_nettype none

package tspd_pkg;

    // Stream bytes and header markers
    localparam logic [7:0] SYNC_VALUE = 8'h47;
    localparam int unsigned PCR_FLAG_BIT = 4;
    localparam logic [7:0] PCR_MIN_LENGTH = 8'd7;

    // Register defaults
    localparam logic [12:0] AUDIO_PID_RESET = 13'h0040;
    localparam logic [12:0] VIDEO_PID_RESET = 13'h0041;

    // Register index, taken from paddr[2]
    localparam logic REG_AUDIO_PID = 1'b0;
    localparam logic REG_VIDEO_PID = 1'b1;

    // Result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Stream select codes
    localparam logic SEL_AUDIO = 1'b0;
    localparam logic SEL_VIDEO = 1'b1;

    // Header status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SYNC = 2'd1;
    localparam logic [1:0] STATUS_LONG_AF  = 2'd2;

    // One result transaction
    typedef struct packed {
        logic        kind;
        logic        stream_select;
        logic [7:0]  payload_byte;
        logic        unit_start;
        logic [12:0] packet_pid;
        logic [3:0]  continuity;
        logic [1:0]  adaptation_control;
        logic        transport_error;
        logic [1:0]  status;
        logic        pcr_valid;
        logic [32:0] pcr_base;
        logic [8:0]  pcr_extension;
    } res_t;

endpackage

`default_nettype wire

>>> src/tspd_parser.sv
// Packet byte counter, header/adaptation capture and result formation.
`timescale 1ns / 1ps
`default_nettype none

module tspd_parser
    import tspd_pkg::*;
#(
    parameter int PACKET_BYTES = 188
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        take,
    input  wire logic [7:0]  stream_byte,
    input  wire logic [12:0] audio_pid,
    input  wire logic [12:0] video_pid,
    output logic             res_valid,
    output res_t             res
);

    localparam int POS_W = $clog2(PACKET_BYTES);
    localparam logic [7:0] MAX_ADAPT = 8'(PACKET_BYTES - 5);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [23:0]      hdr_reg, hdr_next;
    logic             sync_bad_reg, sync_bad_next;
    logic [7:0]       alen_reg, alen_next;
    logic [7:0]       aflags_reg, aflags_next;
    logic [47:0]      pcr_reg, pcr_next;
    logic             pend_reg, pend_next;

    logic        has_adapt;
    logic        has_payload;
    logic        hdr_emit;
    logic        pay_emit;
    logic [3:0]  emit_pos;
    logic [7:0]  eff_len;
    logic [8:0]  pay_start;
    logic [12:0] pid;
    logic        pid_audio;
    logic        pid_video;

    // Control bits of the captured header, valid from byte four on
    assign has_adapt   = hdr_reg[5];
    assign has_payload = hdr_reg[4];

    // State update for the accepted byte
    always_comb
    begin
        pos_next      = (pos_reg == LAST_POS) ? '0 : pos_reg + POS_W'(1);
        hdr_next      = hdr_reg;
        sync_bad_next = sync_bad_reg;
        alen_next     = alen_reg;
        aflags_next   = aflags_reg;
        pcr_next      = pcr_reg;
        if (pos_reg == '0)
        begin
            sync_bad_next = (stream_byte != SYNC_VALUE);
            alen_next     = '0;
            aflags_next   = '0;
            pcr_next      = '0;
        end
        else if (pos_reg <= POS_W'(3))
        begin
            hdr_next = {hdr_reg[15:0], stream_byte};
        end
        else if (has_adapt)
        begin
            if (pos_reg == POS_W'(4))
                alen_next = stream_byte;
            else if (pos_reg == POS_W'(5) && alen_reg != '0)
                aflags_next = stream_byte;
            else if (pos_reg >= POS_W'(6) && pos_reg <= POS_W'(11))
                pcr_next = {pcr_reg[39:0], stream_byte};
        end
    end

    // Header summary goes out on the last byte it needs
    always_comb
    begin
        emit_pos = 4'd4 + ((alen_next < PCR_MIN_LENGTH) ? {1'b0, alen_next[2:0]} : 4'd7);
        hdr_emit = 1'b0;
        if (pos_reg == POS_W'(3))
            hdr_emit = !hdr_next[5];
        else if (pos_reg >= POS_W'(4) && has_adapt)
            hdr_emit = (pos_reg == POS_W'(emit_pos));
    end

    // Unit start flag: loaded at header byte three, cleared by the first routed byte
    always_comb
    begin
        pend_next = pend_reg;
        if (pos_reg == '0)
            pend_next = 1'b0;
        else if (pos_reg == POS_W'(3))
            pend_next = hdr_next[22];
        else if (pay_emit)
            pend_next = 1'b0;
    end

    // Payload routing
    assign eff_len   = (alen_next > MAX_ADAPT) ? MAX_ADAPT : alen_next;
    assign pay_start = has_adapt ? (9'd5 + {1'b0, eff_len}) : 9'd4;
    assign pid       = {hdr_next[20:16], hdr_next[15:8]};
    assign pid_audio = (pid == audio_pid);
    assign pid_video = (pid == video_pid);
    assign pay_emit  = (pos_reg >= POS_W'(4)) && !hdr_emit && has_payload
                       && (9'(pos_reg) >= pay_start) && (pid_audio || pid_video);

    // Result formation
    always_comb
    begin
        res                    = '0;
        res.packet_pid         = pid;
        res.continuity         = hdr_next[3:0];
        res.adaptation_control = hdr_next[5:4];
        res.transport_error    = hdr_next[23];
        if (pay_emit)
        begin
            res.kind          = KIND_PAYLOAD;
            res.stream_select = pid_audio ? SEL_AUDIO : SEL_VIDEO;
            res.payload_byte  = stream_byte;
            res.unit_start    = pend_reg;
        end
        else
        begin
            res.kind = KIND_HEADER;
            if (sync_bad_next)
                res.status = STATUS_BAD_SYNC;
            else if (alen_next > MAX_ADAPT && hdr_next[5])
                res.status = STATUS_LONG_AF;
            else
                res.status = STATUS_OK;
            if (hdr_next[5] && aflags_next[PCR_FLAG_BIT] && alen_next >= PCR_MIN_LENGTH)
            begin
                res.pcr_valid     = 1'b1;
                res.pcr_base      = pcr_next[47:15];
                res.pcr_extension = {pcr_next[8], pcr_next[7:0]};
            end
        end
    end

    assign res_valid = take && (hdr_emit || pay_emit);

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            hdr_reg      <= '0;
            sync_bad_reg <= 1'b0;
            alen_reg     <= '0;
            aflags_reg   <= '0;
            pcr_reg      <= '0;
            pend_reg     <= 1'b0;
        end
        else if (take)
        begin
            pos_reg      <= pos_next;
            hdr_reg      <= hdr_next;
            sync_bad_reg <= sync_bad_next;
            alen_reg     <= alen_next;
            aflags_reg   <= aflags_next;
            pcr_reg      <= pcr_next;
            pend_reg     <= pend_next;
        end
    end

endmodule

`default_nettype wire

>>> src/tspd_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
`timescale 1ns / 1ps
`default_nettype none

module tspd_out_buf
    import tspd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire res_t push_data,
    output logic      full,
    output logic      out_valid,
    input  wire logic out_stall,
    output res_t      out_data
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t main_reg, main_next;
    res_t skid_reg, skid_next;
    logic pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = main_reg;

    // Next buffer contents; push never arrives while the skid entry is held
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                main_next      = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

>>> src/ts_packet_demux.sv
// Top level of the transport stream packet demultiplexer.
//
//  Channel   Direction  Handshake            Contents
//  input     in         in_valid/in_stall    stream_byte
//  output    out        out_valid/out_stall  kind, stream_select, payload_byte, unit_start,
//                                            packet_pid, continuity, adaptation_control,
//                                            transport_error, status, pcr_*
//  config    in         APB write/read       audio_pid (0x0), video_pid (0x4)
//
// One byte is taken every cycle while in_stall is low; its result, if any, is formed from
// the current byte counter and the next values of the capture registers and pushed into
// the output buffer: at most one transaction per clock while in_stall is low.
// A two-entry output buffer lets one result wait while another byte is taken; in_stall
// rises only when both entries are held.
// Reset clears the counter (packet aligned from the first byte) and sets the PID
// registers to 0x40 and 0x41.
`timescale 1ns / 1ps
`default_nettype none

module ts_packet_demux
    import tspd_pkg::*;
#(
    parameter int PACKET_BYTES = 188
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Byte input
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  stream_byte,
    // Result output
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic             stream_select,
    output logic [7:0]       payload_byte,
    output logic             unit_start,
    output logic [12:0]      packet_pid,
    output logic [3:0]       continuity,
    output logic [1:0]       adaptation_control,
    output logic             transport_error,
    output logic [1:0]       status,
    output logic             pcr_valid,
    output logic [32:0]      pcr_base,
    output logic [8:0]       pcr_extension,
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [12:0] audio_pid_reg;
    logic [12:0] video_pid_reg;
    logic        cfg_write;
    logic        take;
    logic        full;
    logic        res_valid;
    res_t        res;
    res_t        out_data;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            audio_pid_reg <= AUDIO_PID_RESET;
            video_pid_reg <= VIDEO_PID_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_AUDIO_PID: audio_pid_reg <= pwdata[12:0];
                REG_VIDEO_PID: video_pid_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            REG_AUDIO_PID: prdata = {19'd0, audio_pid_reg};
            REG_VIDEO_PID: prdata = {19'd0, video_pid_reg};
            default:       prdata = '0;
        endcase
    end

    // Input handshake
    assign in_stall = full;
    assign take     = in_valid && !full;

    tspd_parser #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .stream_byte (stream_byte),
        .audio_pid   (audio_pid_reg),
        .video_pid   (video_pid_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    tspd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Result fields
    assign kind               = out_data.kind;
    assign stream_select      = out_data.stream_select;
    assign payload_byte       = out_data.payload_byte;
    assign unit_start         = out_data.unit_start;
    assign packet_pid         = out_data.packet_pid;
    assign continuity         = out_data.continuity;
    assign adaptation_control = out_data.adaptation_control;
    assign transport_error    = out_data.transport_error;
    assign status             = out_data.status;
    assign pcr_valid          = out_data.pcr_valid;
    assign pcr_base           = out_data.pcr_base;
    assign pcr_extension      = out_data.pcr_extension;

endmodule

`default_nettype wire
